// File: hdl/dq_pkg.sv
// Package for the double-ended queue: depth, widths, action and status codes,
// controller state type and the controller-to-datapath command bundle.
// No dependencies.
package dq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK       = 3'd4,
    ACT_DROP       = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CTL_IDLE = 1'b0,
    CTL_LOAD = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic accept;  // take the input transaction, update ring state
    logic load;    // move the pending result into the output register
  } ctl_cmd_t;

endpackage

// File: hdl/dq_ifs.sv
// Handshake interfaces for the double-ended queue: one for action transactions,
// one for result transactions. Depends on dq_pkg.
interface dq_item_if
  import dq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           peek_position;
  logic [POS_W-1:0]           drop_count;

  modport source (output valid, action, value, peek_position, drop_count, input ready);
  modport sink   (input valid, action, value, peek_position, drop_count, output ready);
endinterface

interface dq_result_if
  import dq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  data;
  logic [STATUS_W-1:0]        status;
  logic [CNT_W-1:0]           occupancy;

  modport source (output valid, data, status, occupancy, input ready);
  modport sink   (input valid, data, status, occupancy, output ready);
endinterface

// File: hdl/dq_ctrl.sv
// Controller for the double-ended queue: two-state sequencer and output valid flag.
// Depends on dq_pkg.
module dq_ctrl
  import dq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  logic     result_ready_i,
  output logic     item_ready_o,
  output logic     result_valid_o,
  output ctl_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CTL_IDLE: begin
        if (cmd_o.accept) state_d = CTL_LOAD;
      end
      CTL_LOAD: begin
        if (cmd_o.load) state_d = CTL_IDLE;
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  always_comb begin
    item_ready_o = 1'b0;
    cmd_o        = '0;
    case (state_q)
      CTL_IDLE: begin
        item_ready_o = 1'b1;
        cmd_o.accept = item_valid_i;
      end
      CTL_LOAD: begin
        cmd_o.load = !out_valid_q || result_ready_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) out_valid_d = 1'b1;
    else if (result_ready_i) out_valid_d = 1'b0;
  end

  assign result_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/dq_datapath.sv
// Datapath for the double-ended queue: ring store, front index, entry count,
// pending result and output register. Depends on dq_pkg.
module dq_datapath
  import dq_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctl_cmd_t                  cmd_i,
  input  logic [ACTION_W-1:0]       action_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [POS_W-1:0]          peek_position_i,
  input  logic [POS_W-1:0]          drop_count_i,
  output logic signed [VALUE_W-1:0] data_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [CNT_W-1:0]          occupancy_o
);

  localparam logic [CNT_W-1:0] FullCount = CNT_W'(DEPTH);

  logic [VALUE_W-1:0] mem_q [DEPTH];
  logic [VALUE_W-1:0] rd_q;

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             rd_ok_d, rd_ok_q;
  status_e          status_d, pend_status_q;
  logic [CNT_W-1:0] pend_occ_q;

  logic signed [VALUE_W-1:0] out_data_q;
  logic [STATUS_W-1:0]       out_status_q;
  logic [CNT_W-1:0]          out_occ_q;

  logic is_full, is_empty;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] pos_m1;

  assign is_full  = (count_q == FullCount);
  assign is_empty = (count_q == '0);
  assign count_m1 = count_q - CNT_W'(1);
  assign pos_m1   = peek_position_i[IDX_W-1:0] - IDX_W'(1);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    wr_en    = 1'b0;
    wr_addr  = front_q + count_q[IDX_W-1:0];
    rd_addr  = front_q;
    rd_ok_d  = 1'b0;
    status_d = ST_OK;
    case (action_i)
      ACT_PUSH_BACK: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = front_q - IDX_W'(1);
          front_d = front_q - IDX_W'(1);
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_ok_d = 1'b1;
          front_d = front_q + IDX_W'(1);
          count_d = count_m1;
        end
      end
      ACT_POP_BACK: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_ok_d = 1'b1;
          rd_addr = front_q + count_m1[IDX_W-1:0];
          count_d = count_m1;
        end
      end
      ACT_PEEK: begin
        rd_addr = front_q + pos_m1;
        if (peek_position_i == '0 || CNT_W'(peek_position_i) > count_q) begin
          status_d = ST_EMPTY;
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      ACT_DROP: begin
        if (CNT_W'(drop_count_i) >= count_q) begin
          front_d = front_q + count_q[IDX_W-1:0];
          count_d = '0;
        end else begin
          front_d = front_q + drop_count_i[IDX_W-1:0];
          count_d = count_q - CNT_W'(drop_count_i);
        end
      end
      default: ;
    endcase
  end

  // Ring store: at most one write and one registered read per accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (wr_en) mem_q[wr_addr] <= value_i;
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_ok_q       <= rd_ok_d;
      pend_status_q <= status_d;
      pend_occ_q    <= count_d;
    end
    if (cmd_i.load) begin
      out_data_q   <= rd_ok_q ? $signed(rd_q) : '0;
      out_status_q <= pend_status_q;
      out_occ_q    <= pend_occ_q;
    end
  end

  assign data_o      = out_data_q;
  assign status_o    = out_status_q;
  assign occupancy_o = out_occ_q;

endmodule

// File: hdl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values held in a 16-entry ring
// store. Each transaction on item_i carries one action (push back, push front,
// pop front, pop back, peek, drop front) and yields exactly one transaction on
// result_o with data, status and the occupancy after the action. The accept edge
// updates the front index and count and performs the ring store's write or
// registered read; the pending result then moves into the output register once
// that register is free. The output register lets a new action be accepted while
// an earlier result still waits on result_o.ready; a new action is accepted only
// after the previous result has been loaded. Depends on dq_pkg, dq_ifs,
// dq_ctrl and dq_datapath.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dq_item_if.sink     item_i,
  dq_result_if.source result_o
);

  ctl_cmd_t cmd;

  // Sequence accept and result load.
  dq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_i.valid),
    .result_ready_i (result_o.ready),
    .item_ready_o   (item_i.ready),
    .result_valid_o (result_o.valid),
    .cmd_o          (cmd)
  );

  // Hold the ring, the indices and the result registers.
  dq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (item_i.action),
    .value_i         (item_i.value),
    .peek_position_i (item_i.peek_position),
    .drop_count_i    (item_i.drop_count),
    .data_o          (result_o.data),
    .status_o        (result_o.status),
    .occupancy_o     (result_o.occupancy)
  );

  // Occupancy never exceeds the ring depth.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.occupancy <= CNT_W'(DEPTH)))
    else $error("occupancy above depth");

  // A rejected push only happens on a full ring.
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.status == ST_FULL) |-> (result_o.occupancy == CNT_W'(DEPTH)))
    else $error("full status with free entries");

  // Nonzero data only comes with an ok status.
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.data != '0) |-> (result_o.status == ST_OK))
    else $error("data on failed action");

  // After an accept the controller finishes the action before taking another.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("second accept while action in flight");

endmodule
